### hw/rtl/uerf_pkg.sv
// ----------------------------------------------------------------------------
// Ultrasonic echo range filter package
// Shared types and constants for the range filter and its sorting cells.
// ----------------------------------------------------------------------------
package uerf_pkg;

	localparam int unsigned DistW   = 16;
	localparam int unsigned KeyW    = DistW + 1;
	localparam logic [10:0] DistScale = 11'd1124;
	localparam logic [15:0] Sat16   = 16'hFFFF;

	// A sort key carries an empty mark above the distance, so empty slots sort last.
	typedef logic [KeyW-1:0] key_t;

	typedef struct packed {
		logic load;
		logic swap;
		logic phase;
		logic shift;
	} cell_ctrl_t;

	typedef enum logic [2:0] {
		REG_TRIGGER_PERIOD = 3'd0,
		REG_ECHO_TIMEOUT   = 3'd1,
		REG_MIN_DISTANCE   = 3'd2,
		REG_MAX_DISTANCE   = 3'd3,
		REG_MAX_JUMP       = 3'd4,
		REG_EMA_ALPHA      = 3'd5,
		REG_FRESH_WINDOW   = 3'd6,
		REG_MIN_STREAK     = 3'd7
	} reg_index_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_EVAL,
		ST_CHECK,
		ST_LOAD,
		ST_SORT,
		ST_SHIFT,
		ST_MEDIAN,
		ST_EMA1,
		ST_EMA2,
		ST_FINISH
	} state_t;

endpackage

### hw/rtl/uerf_cell.sv
// ----------------------------------------------------------------------------
// Sorting cell
// One slot of the odd-even transposition sorter; also shifts towards cell 0.
// ----------------------------------------------------------------------------
module uerf_cell #(
	parameter bit ODD = 1'b0
) (
	input  logic                clk,
	input  uerf_pkg::cell_ctrl_t ctrl,
	input  uerf_pkg::key_t      load_key,
	input  uerf_pkg::key_t      left_key,
	input  uerf_pkg::key_t      right_key,
	output uerf_pkg::key_t      key
);
	import uerf_pkg::*;

	key_t key_q;
	logic pair_left;

	// In a given phase this cell is the lower slot of its pair when parities agree.
	assign pair_left = (ctrl.phase == ODD);
	assign key = key_q;

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			key_q <= load_key;
		end else if (ctrl.swap) begin
			if (pair_left) begin
				key_q <= (right_key < key_q) ? right_key : key_q;
			end else begin
				key_q <= (left_key > key_q) ? left_key : key_q;
			end
		end else if (ctrl.shift) begin
			key_q <= right_key;
		end
	end

endmodule

### hw/rtl/ultrasonic_echo_range_filter.sv
// ----------------------------------------------------------------------------
// Ultrasonic echo range filter
// Trigger scheduling, echo timing, slew limit, median and EMA of range samples.
// ----------------------------------------------------------------------------
// Items arrive on the s_ channel: s_tuser is the kind (0 service tick, 1 echo
// edge), s_tdata carries the times and the echo level. Every item gives one
// result transaction on the m_ channel. Registers are written on the cfg_
// channel, which is always ready. The user must write them only while the
// block is idle; the block itself does not enforce it. An item is worked on
// alone. An edge, or a tick that takes no sample, goes from EVAL to FINISH,
// where its result enters the output register; a pulse that fails the
// distance check also passes through CHECK. A tick that takes a sample runs
// the window through the row of sorting cells: LOAD, the WINDOW transposition
// passes, the (fill-1)/2 shifts to cell 0, MEDIAN and, but for the first sample, EMA1 and EMA2.
// The next item is accepted in the cycle after the result reaches the output
// register, so a stalled receiver holds back at most one further item.
// Reset returns the cfg_ registers to their defaults and clears the tracking
// state; the history slots are only read once written.
// ----------------------------------------------------------------------------
module ultrasonic_echo_range_filter #(
	parameter int unsigned WINDOW = 5
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [71:0]  s_tdata,   // time_us[31:0], time_ms[63:32], echo_level[64]
	input  logic         s_tuser,   // cmd[0]
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [119:0] m_tdata,   // trigger[0], sample_taken[1], limited_distance[17:2],
	                                // filtered_distance[33:18], sample_held[34],
	                                // timeout_flag[35], fresh[36], good_run[52:37],
	                                // timeout_total[68:53], jump_count[84:69],
	                                // sample_age_ms[116:85]
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [2:0]   cfg_index,
	input  logic [31:0]  cfg_data
);
	import uerf_pkg::*;

	localparam int unsigned FillW = $clog2(WINDOW + 1);
	localparam int unsigned CntW  = $clog2(WINDOW + 1);
	localparam logic [FillW-1:0] FillMax = FillW'(WINDOW);
	localparam logic [CntW-1:0]  PassLast = CntW'(WINDOW - 1);

	// Configuration
	logic [31:0] period_q;
	logic [15:0] echo_to_q, min_dist_q, max_dist_q, max_jump_q, fresh_win_q, min_streak_q;
	logic [8:0]  alpha_q;

	// Item
	logic        cmd_q, level_q;
	logic [31:0] now_us_q, now_ms_q;

	// Tracking state
	state_t      state_q, state_d;
	logic [31:0] trig_time_q, rise_time_q, pulse_width_q, last_ms_q;
	logic        once_q, waiting_q, armed_q, await_fall_q, pulse_rdy_q;
	logic        ema_valid_q, present_q, timed_out_q;
	logic [15:0] ema_q, last_dist_q, streak_q, timeouts_q, jumps_q;
	logic [FillW-1:0] fill_q;
	logic [DistW-1:0] hist_q [WINDOW];
	logic [42:0] prod_q;
	logic [CntW-1:0] cnt_q;
	logic [15:0] med_q;
	logic [24:0] p1_q;
	logic        trig_q, taken_q;

	// Output register
	logic         m_valid_q;
	logic [119:0] m_data_q;

	// Combinational
	logic [31:0] since_trig;
	logic        trig_now, bad_width, out_range, out_free;
	logic [15:0] dist_raw, dist_lim;
	logic [16:0] jump_up, jump_dn, mid_sum;
	logic        jump_hi, jump_lo;
	logic [8:0]  alpha_sat;
	logic [31:0] age;
	logic        fresh;
	cell_ctrl_t  cctrl;
	key_t        keys [WINDOW+1];

	assign cfg_ready = 1'b1;
	assign s_tready  = (state_q == ST_IDLE);
	assign m_tvalid  = m_valid_q;
	assign m_tdata   = m_data_q;
	assign out_free  = !m_valid_q || m_tready;

	assign since_trig = now_us_q - trig_time_q;
	assign trig_now   = !cmd_q && !waiting_q && (!once_q || since_trig >= period_q);
	assign bad_width  = (pulse_width_q == 32'd0) || (pulse_width_q >= {16'd0, echo_to_q});
	assign dist_raw   = prod_q[23:8];
	assign out_range  = (prod_q[42:24] != '0) || (dist_raw < min_dist_q)
		|| (dist_raw > max_dist_q);
	assign jump_up    = {1'b0, last_dist_q} + {1'b0, max_jump_q};
	assign jump_dn    = {1'b0, last_dist_q} - {1'b0, max_jump_q};
	assign jump_hi    = present_q && (dist_raw > last_dist_q)
		&& ((dist_raw - last_dist_q) > max_jump_q);
	assign jump_lo    = present_q && (dist_raw < last_dist_q)
		&& ((last_dist_q - dist_raw) > max_jump_q);
	assign dist_lim   = jump_hi ? jump_up[15:0] : (jump_lo ? jump_dn[15:0] : dist_raw);
	assign mid_sum    = {1'b0, keys[0][DistW-1:0]} + {1'b0, keys[1][DistW-1:0]};
	assign alpha_sat  = (alpha_q[8] && (alpha_q[7:0] != 8'd0)) ? 9'd256 : alpha_q;
	assign age        = present_q ? (now_ms_q - last_ms_q) : 32'hFFFF_FFFF;
	assign fresh      = present_q && (streak_q >= min_streak_q) && (age <= {16'd0, fresh_win_q});

	always_comb begin
		cctrl = '0;
		cctrl.load  = (state_q == ST_LOAD);
		cctrl.swap  = (state_q == ST_SORT);
		cctrl.phase = cnt_q[0];
		cctrl.shift = (state_q == ST_SHIFT) && (cnt_q != '0);
	end

	// Row of sorting cells; the slot beyond the last reads as empty.
	assign keys[WINDOW] = '1;
	for (genvar i = 0; i < WINDOW; i++) begin : g_cell
		key_t lkey, ld;
		if (i == 0) begin : g_first
			assign lkey = '0;
		end else begin : g_rest
			assign lkey = keys[i-1];
		end
		assign ld = (FillW'(i) < fill_q) ? {1'b0, hist_q[i]} : {1'b1, {DistW{1'b0}}};
		uerf_cell #(.ODD(1'(i % 2))) u_cell (
			.clk       (clk),
			.ctrl      (cctrl),
			.load_key  (ld),
			.left_key  (lkey),
			.right_key (keys[i+1]),
			.key       (keys[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:   if (s_tvalid) state_d = ST_EVAL;
			ST_EVAL: begin
				if (!cmd_q && !trig_now && pulse_rdy_q && !bad_width) state_d = ST_CHECK;
				else state_d = ST_FINISH;
			end
			ST_CHECK:  state_d = out_range ? ST_FINISH : ST_LOAD;
			ST_LOAD:   state_d = ST_SORT;
			ST_SORT:   if (cnt_q == PassLast) state_d = ST_SHIFT;
			ST_SHIFT:  if (cnt_q == '0) state_d = ST_MEDIAN;
			ST_MEDIAN: state_d = ema_valid_q ? ST_EMA1 : ST_FINISH;
			ST_EMA1:   state_d = ST_EMA2;
			ST_EMA2:   state_d = ST_FINISH;
			ST_FINISH: if (out_free) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// Item capture and working registers without reset
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			cmd_q    <= s_tuser;
			now_us_q <= s_tdata[31:0];
			now_ms_q <= s_tdata[63:32];
			level_q  <= s_tdata[64];
		end
		if (state_q == ST_EVAL) prod_q <= pulse_width_q * {32'd0, DistScale};
		if (state_q == ST_CHECK && !out_range) begin
			hist_q[0] <= dist_lim;
			for (int i = 1; i < WINDOW; i++) hist_q[i] <= hist_q[i-1];
		end
		if (state_q == ST_MEDIAN) med_q <= fill_q[0] ? keys[0][DistW-1:0] : mid_sum[16:1];
		if (state_q == ST_EMA1) p1_q <= alpha_sat * {9'd0, med_q};
		if (state_q == ST_FINISH && out_free) begin
			m_data_q <= {3'd0, age, jumps_q, timeouts_q, streak_q, fresh, timed_out_q,
				present_q, ema_q, last_dist_q, taken_q, trig_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q     <= 32'd60000;
			echo_to_q    <= 16'd30000;
			min_dist_q   <= 16'd512;
			max_dist_q   <= 16'd51200;
			max_jump_q   <= 16'd6400;
			alpha_q      <= 9'd77;
			fresh_win_q  <= 16'd100;
			min_streak_q <= 16'd2;
		end else if (cfg_valid && cfg_ready) begin
			case (reg_index_t'(cfg_index))
				REG_TRIGGER_PERIOD: period_q     <= cfg_data;
				REG_ECHO_TIMEOUT:   echo_to_q    <= cfg_data[15:0];
				REG_MIN_DISTANCE:   min_dist_q   <= cfg_data[15:0];
				REG_MAX_DISTANCE:   max_dist_q   <= cfg_data[15:0];
				REG_MAX_JUMP:       max_jump_q   <= cfg_data[15:0];
				REG_EMA_ALPHA:      alpha_q      <= cfg_data[8:0];
				REG_FRESH_WINDOW:   fresh_win_q  <= cfg_data[15:0];
				REG_MIN_STREAK:     min_streak_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			trig_time_q <= '0; rise_time_q <= '0; pulse_width_q <= '0; last_ms_q <= '0;
			once_q <= 1'b0; waiting_q <= 1'b0; armed_q <= 1'b0; await_fall_q <= 1'b0;
			pulse_rdy_q <= 1'b0; ema_valid_q <= 1'b0; present_q <= 1'b0;
			timed_out_q <= 1'b0; ema_q <= '0; last_dist_q <= '0; streak_q <= '0;
			timeouts_q <= '0; jumps_q <= '0; fill_q <= '0; cnt_q <= '0;
			trig_q <= 1'b0; taken_q <= 1'b0; m_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_EVAL: begin
					trig_q  <= trig_now;
					taken_q <= 1'b0;
					if (cmd_q) begin
						if (armed_q) begin
							if (level_q) begin
								rise_time_q  <= now_us_q;
								await_fall_q <= 1'b1;
							end else if (await_fall_q) begin
								pulse_width_q <= now_us_q - rise_time_q;
								pulse_rdy_q   <= 1'b1;
								await_fall_q  <= 1'b0;
								armed_q       <= 1'b0;
							end
						end
					end else if (trig_now) begin
						armed_q      <= 1'b1;
						await_fall_q <= 1'b0;
						pulse_rdy_q  <= 1'b0;
						trig_time_q  <= now_us_q;
						once_q       <= 1'b1;
						waiting_q    <= 1'b1;
					end else if (pulse_rdy_q) begin
						pulse_rdy_q <= 1'b0;
						waiting_q   <= 1'b0;
						if (bad_width) begin
							timed_out_q <= 1'b1;
							if (timeouts_q != Sat16) timeouts_q <= timeouts_q + 16'd1;
						end
					end else if (waiting_q && since_trig > {16'd0, echo_to_q}) begin
						waiting_q    <= 1'b0;
						armed_q      <= 1'b0;
						await_fall_q <= 1'b0;
						timed_out_q  <= 1'b1;
						if (timeouts_q != Sat16) timeouts_q <= timeouts_q + 16'd1;
					end
				end
				ST_CHECK: begin
					if (out_range) begin
						timed_out_q <= 1'b1;
						if (timeouts_q != Sat16) timeouts_q <= timeouts_q + 16'd1;
					end else begin
						if ((jump_hi || jump_lo) && jumps_q != Sat16) jumps_q <= jumps_q + 16'd1;
						last_dist_q <= dist_lim;
						if (fill_q != FillMax) fill_q <= fill_q + 1'b1;
						present_q   <= 1'b1;
						timed_out_q <= 1'b0;
						if (streak_q != Sat16) streak_q <= streak_q + 16'd1;
						last_ms_q   <= now_ms_q;
						taken_q     <= 1'b1;
					end
				end
				ST_LOAD: cnt_q <= '0;
				ST_SORT: begin
					if (cnt_q == PassLast) cnt_q <= CntW'((fill_q - 1'b1) >> 1);
					else cnt_q <= cnt_q + 1'b1;
				end
				ST_SHIFT: if (cnt_q != '0) cnt_q <= cnt_q - 1'b1;
				ST_MEDIAN: begin
					if (!ema_valid_q) begin
						ema_q       <= fill_q[0] ? keys[0][DistW-1:0] : mid_sum[16:1];
						ema_valid_q <= 1'b1;
					end
				end
				ST_EMA2: begin
					ema_q <= 16'((25'(p1_q) + (25'(9'd256 - alpha_sat) * 25'(ema_q)) + 25'd128) >> 8);
				end
				default: ;
			endcase
			if (state_q == ST_FINISH && out_free) m_valid_q <= 1'b1;
			else if (m_tready) m_valid_q <= 1'b0;
		end
	end

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n) fill_q <= FillMax)
		else $error("history fill count beyond window");
	a_taken_has: assert property (@(posedge clk) disable iff (!arst_n)
		m_valid_q |-> (!m_data_q[1] || m_data_q[34]))
		else $error("sample taken without sample present");
	a_trig_excl: assert property (@(posedge clk) disable iff (!arst_n)
		m_valid_q |-> !(m_data_q[0] && m_data_q[1]))
		else $error("trigger and sample in the same result");
	a_rdy_fall: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("second item taken while one is in work");

endmodule
